/* src/esc_pkg.sv */
// Shared constants, types and helpers for the environmental sensor compensation block.
// Used by the pipelined divider, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  // Datapath word width; every intermediate wraps at this width.
  localparam int DW = 32;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TEMP  = 3'd0,
    REG_PLOW  = 3'd1,
    REG_PMID  = 3'd2,
    REG_PLAST = 3'd3,
    REG_HUM   = 3'd4
  } cfg_idx_t;

  // Formula constants.
  localparam logic [31:0] C_P_OFFSET  = 32'd64000;
  localparam logic [31:0] C_H_OFFSET  = 32'd76800;
  localparam logic [31:0] C_P_FULL    = 32'd1048576;
  localparam logic [31:0] C_P_SCALE   = 32'd3125;
  localparam logic [31:0] C_H_CLAMP   = 32'd419430400;
  localparam logic [31:0] C_H_BIAS    = 32'd2097152;
  localparam logic [31:0] C_HALF15    = 32'd32768;
  localparam logic [31:0] C_RND14     = 32'd16384;
  localparam logic [31:0] C_RND13     = 32'd8192;
  localparam logic [31:0] C_T_RND     = 32'd128;

  // Side data that rides along with each divider transfer.
  typedef struct packed {
    logic [31:0] temp;
    logic [13:0] hum;
    logic        big;
    logic        zero;
  } div_side_t;

  // Arithmetic right shift of a 32-bit two's complement pattern.
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

endpackage

`default_nettype wire

/* src/esc_if.sv */
// Valid/ready channel interfaces for raw samples and compensated results.
// Stand-alone; the payload widths follow the sample and result formats.
`timescale 1ns / 1ps
`default_nettype none

interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_pa;
  logic        [13:0] humidity_centi;

  modport source (output valid, temperature_centi, pressure_pa, humidity_centi, input ready);
  modport sink   (input valid, temperature_centi, pressure_pa, humidity_centi, output ready);
endinterface

`default_nettype wire

/* src/env_sensor_compensation.sv */
// Top level of the environmental sensor compensation pipeline.
// Depends on esc_pkg, the channel interfaces in esc_if and the divider esc_div.
//
// Channel | Direction | Payload
// in_ch   | sink      | raw_temperature[20], raw_pressure[20], raw_humidity[16]
// out_ch  | source    | temperature_centi[32 s], pressure_pa[32], humidity_centi[14]
// cfg_*   | write     | cfg_we, cfg_index[3], cfg_wdata[64]
//
// One sample enters per cycle while the pipeline advances; each result passes through
// 17 front stages, 32 divider stages and 3 pressure correction stages.
// The whole pipeline advances together; it holds when a result waits on out_ch.ready.
// Synchronous active-low reset clears the stage valid bits and the coefficients.
`timescale 1ns / 1ps
`default_nettype none

module env_sensor_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  esc_in_if.sink           in_ch,
  esc_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  import esc_pkg::*;

  localparam int NF = 17;

  // Coefficient registers.
  logic [47:0] cfg_temp_r;
  logic [63:0] cfg_plow_r, cfg_pmid_r, cfg_hum_r;
  logic [15:0] cfg_plast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_temp_r  <= '0;
      cfg_plow_r  <= '0;
      cfg_pmid_r  <= '0;
      cfg_plast_r <= '0;
      cfg_hum_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP:  cfg_temp_r  <= cfg_wdata[47:0];
        REG_PLOW:  cfg_plow_r  <= cfg_wdata;
        REG_PMID:  cfg_pmid_r  <= cfg_wdata;
        REG_PLAST: cfg_plast_r <= cfg_wdata[15:0];
        REG_HUM:   cfg_hum_r   <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Unpacked coefficients, extended to the word width.
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'b0, cfg_temp_r[15:0]};
  assign t2 = {{16{cfg_temp_r[31]}}, cfg_temp_r[31:16]};
  assign t3 = {{16{cfg_temp_r[47]}}, cfg_temp_r[47:32]};
  assign p1 = {16'b0, cfg_plow_r[15:0]};
  assign p2 = {{16{cfg_plow_r[31]}}, cfg_plow_r[31:16]};
  assign p3 = {{16{cfg_plow_r[47]}}, cfg_plow_r[47:32]};
  assign p4 = {{16{cfg_plow_r[63]}}, cfg_plow_r[63:48]};
  assign p5 = {{16{cfg_pmid_r[15]}}, cfg_pmid_r[15:0]};
  assign p6 = {{16{cfg_pmid_r[31]}}, cfg_pmid_r[31:16]};
  assign p7 = {{16{cfg_pmid_r[47]}}, cfg_pmid_r[47:32]};
  assign p8 = {{16{cfg_pmid_r[63]}}, cfg_pmid_r[63:48]};
  assign p9 = {{16{cfg_plast_r[15]}}, cfg_plast_r};
  assign h1 = {24'b0, cfg_hum_r[7:0]};
  assign h2 = {{16{cfg_hum_r[23]}}, cfg_hum_r[23:8]};
  assign h3 = {24'b0, cfg_hum_r[31:24]};
  assign h4 = {{20{cfg_hum_r[43]}}, cfg_hum_r[43:32]};
  assign h5 = {{20{cfg_hum_r[55]}}, cfg_hum_r[55:44]};
  assign h6 = {{24{cfg_hum_r[63]}}, cfg_hum_r[63:56]};

  // Global advance: everything moves unless a finished result is held.
  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Front stage valid bits; bit 0 is stage 1.
  logic [NF-1:0] fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[NF-2:0], in_ch.valid};
    end
  end

  // Front stage payload registers.
  logic [31:0] s1_x_r, s1_d_r, s2_ma_r, s2_dd_r, s3_a_r, s3_b_r, s4_a_r, s4_bb_r;
  logic [31:0] s5_fine_r, s6_pa_r, s6_ha_r;
  logic [31:0] s7_dd_r, s7_a5_r, s7_a2_r, s7_h5_r, s7_h6_r, s7_h3_r;
  logic [31:0] s8_dd11_r, s8_dd13_r, s8_a5_r, s8_a2_r, s8_hc1_r, s8_hc2_r;
  logic [31:0] s9_b6_r, s9_c3_r, s9_a5_r, s9_a2_r, s9_hc_r;
  logic [31:0] s10_b_r, s10_x_r, s10_hc_r, s11_mp1_r, s11_pv_r, s11_mh2_r;
  logic [31:0] s12_div_r, s12_pm_r, s12_hq_r, s13_hx_r, s14_hx_r, s14_hdd_r;
  logic [31:0] s15_hx_r, s15_ht_r;
  logic [6:0]  s16_hint_r;
  logic [9:0]  s16_hfr_r;
  logic [13:0] s17_hum_r;

  // Delay lines for values carried unchanged between their use points.
  logic [19:0] up_d_r  [1:10];
  logic [15:0] uh_d_r  [1:7];
  logic [31:0] tmp_d_r [6:17];
  logic [31:0] hb_d_r  [8:12];
  logic [31:0] div_d_r [13:17];
  logic [31:0] num_d_r [13:17];
  logic        big_d_r [13:17];

  // Combinational helpers between stages.
  logic [31:0] pd, b10, c10, uh_sh, hd, hx16, hcl;
  logic [16:0] hum16;
  logic [19:0] hfr_prod;
  logic [17:0] q10_prod;

  always_comb begin
    pd       = asr(s6_pa_r, 2);
    b10      = s9_b6_r + (s9_a5_r << 1);
    c10      = asr(s9_c3_r, 3);
    uh_sh    = {2'b0, uh_d_r[7], 14'b0};
    hd       = asr(s13_hx_r, 15);
    hx16     = s15_hx_r - asr(s15_ht_r, 4);
    // Clamp the Q10.22 humidity to the valid range.
    if (hx16[31]) begin
      hcl = '0;
    end else if (hx16 > C_H_CLAMP) begin
      hcl = C_H_CLAMP;
    end else begin
      hcl = hx16;
    end
    hum16    = hcl[28:12];
    hfr_prod = {10'b0, hum16[9:0]} * 20'd1000;
    // Divide the fraction by ten through a reciprocal; exact below 1029.
    q10_prod = {8'b0, s16_hfr_r} * 18'd205;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: temperature offsets.
      s1_x_r    <= {15'b0, in_ch.raw_temperature[19:3]} - (t1 << 1);
      s1_d_r    <= {16'b0, in_ch.raw_temperature[19:4]} - t1;
      up_d_r[1] <= in_ch.raw_pressure;
      uh_d_r[1] <= in_ch.raw_humidity;
      for (int k = 2; k <= 10; k++) up_d_r[k] <= up_d_r[k-1];
      for (int k = 2; k <= 7; k++) uh_d_r[k] <= uh_d_r[k-1];
      // Stages 2 to 5: fine temperature.
      s2_ma_r   <= s1_x_r * t2;
      s2_dd_r   <= s1_d_r * s1_d_r;
      s3_a_r    <= asr(s2_ma_r, 11);
      s3_b_r    <= asr(s2_dd_r, 12);
      s4_a_r    <= s3_a_r;
      s4_bb_r   <= s3_b_r * t3;
      s5_fine_r <= s4_a_r + asr(s4_bb_r, 14);
      // Stage 6: temperature result and offsets for pressure and humidity.
      tmp_d_r[6] <= asr((s5_fine_r << 2) + s5_fine_r + C_T_RND, 8);
      for (int k = 7; k <= 17; k++) tmp_d_r[k] <= tmp_d_r[k-1];
      s6_pa_r   <= asr(s5_fine_r, 1) - C_P_OFFSET;
      s6_ha_r   <= s5_fine_r - C_H_OFFSET;
      // Stage 7: first products.
      s7_dd_r   <= pd * pd;
      s7_a5_r   <= s6_pa_r * p5;
      s7_a2_r   <= p2 * s6_pa_r;
      s7_h5_r   <= h5 * s6_ha_r;
      s7_h6_r   <= s6_ha_r * h6;
      s7_h3_r   <= s6_ha_r * h3;
      // Stage 8: scaling.
      s8_dd11_r <= asr(s7_dd_r, 11);
      s8_dd13_r <= asr(s7_dd_r, 13);
      s8_a5_r   <= s7_a5_r;
      s8_a2_r   <= s7_a2_r;
      hb_d_r[8] <= asr(uh_sh - (h4 << 20) - s7_h5_r + C_RND14, 15);
      for (int k = 9; k <= 12; k++) hb_d_r[k] <= hb_d_r[k-1];
      s8_hc1_r  <= asr(s7_h6_r, 10);
      s8_hc2_r  <= asr(s7_h3_r, 11) + C_HALF15;
      // Stage 9: second products.
      s9_b6_r   <= s8_dd11_r * p6;
      s9_c3_r   <= p3 * s8_dd13_r;
      s9_a5_r   <= s8_a5_r;
      s9_a2_r   <= s8_a2_r;
      s9_hc_r   <= s8_hc1_r * s8_hc2_r;
      // Stage 10: pressure sums and the humidity bias.
      s10_b_r   <= asr(b10, 2) + (p4 << 16);
      s10_x_r   <= C_HALF15 + asr(c10 + asr(s9_a2_r, 1), 18);
      s10_hc_r  <= asr(s9_hc_r, 10) + C_H_BIAS;
      // Stage 11: divisor product, scaled raw pressure and humidity product.
      s11_mp1_r <= s10_x_r * p1;
      s11_pv_r  <= (C_P_FULL - {12'b0, up_d_r[10]}) - asr(s10_b_r, 12);
      s11_mh2_r <= s10_hc_r * h2;
      // Stage 12.
      s12_div_r <= asr(s11_mp1_r, 15);
      s12_pm_r  <= s11_pv_r * C_P_SCALE;
      s12_hq_r  <= asr(s11_mh2_r + C_RND13, 14);
      // Stage 13: dividend selection for large values and the humidity product.
      div_d_r[13] <= s12_div_r;
      num_d_r[13] <= s12_pm_r[31] ? s12_pm_r : (s12_pm_r << 1);
      big_d_r[13] <= s12_pm_r[31];
      for (int k = 14; k <= 17; k++) begin
        div_d_r[k] <= div_d_r[k-1];
        num_d_r[k] <= num_d_r[k-1];
        big_d_r[k] <= big_d_r[k-1];
      end
      s13_hx_r  <= hb_d_r[12] * s12_hq_r;
      // Stages 14 to 17: humidity correction, clamp and conversion.
      s14_hx_r  <= s13_hx_r;
      s14_hdd_r <= hd * hd;
      s15_hx_r  <= s14_hx_r;
      s15_ht_r  <= asr(s14_hdd_r, 7) * h1;
      s16_hint_r <= hum16[16:10];
      s16_hfr_r <= hfr_prod[19:10];
      s17_hum_r <= ({7'b0, s16_hint_r} * 14'd100) + {7'b0, q10_prod[17:11]};
    end
  end

  // Division of the scaled pressure.
  div_side_t   side_in, side_out;
  logic        dv_valid;
  logic [31:0] dv_quo;

  assign side_in.temp = tmp_d_r[17];
  assign side_in.hum  = s17_hum_r;
  assign side_in.big  = big_d_r[17];
  assign side_in.zero = (div_d_r[17] == '0);

  esc_div #(
    .PW($bits(div_side_t))
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (fv_r[NF-1]),
    .dividend (num_d_r[17]),
    .divisor  (div_d_r[17]),
    .side_in  (side_in),
    .out_valid(dv_valid),
    .quotient (dv_quo),
    .side_out (side_out)
  );

  // Pressure correction stages and the output register.
  logic [2:0]  pv_r;
  logic [31:0] pp_pres, pp_q3;
  logic [31:0] pp1_pres_r, pp1_sq_r, pp1_d8_r, pp2_pres_r, pp2_c9_r, pp2_d8_r;
  div_side_t   pp1_side_r, pp2_side_r;
  logic signed [31:0] temp_out_r;
  logic [31:0] pres_out_r;
  logic [13:0] hum_out_r;

  assign pp_pres = side_out.big ? (dv_quo << 1) : dv_quo;
  assign pp_q3   = {3'b0, pp_pres[31:3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[1:0], dv_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp1_pres_r <= pp_pres;
      pp1_sq_r   <= pp_q3 * pp_q3;
      pp1_d8_r   <= {2'b0, pp_pres[31:2]} * p8;
      pp1_side_r <= side_out;
      pp2_pres_r <= pp1_pres_r;
      pp2_c9_r   <= p9 * {13'b0, pp1_sq_r[31:13]};
      pp2_d8_r   <= pp1_d8_r;
      pp2_side_r <= pp1_side_r;
      temp_out_r <= $signed(pp2_side_r.temp);
      hum_out_r  <= pp2_side_r.hum;
      pres_out_r <= pp2_side_r.zero ? '0 :
                    pp2_pres_r + asr(asr(pp2_c9_r, 12) + asr(pp2_d8_r, 13) + p7, 4);
    end
  end

  assign out_ch.valid             = pv_r[2];
  assign out_ch.temperature_centi = temp_out_r;
  assign out_ch.pressure_pa       = pres_out_r;
  assign out_ch.humidity_centi    = hum_out_r;

  // A delivered humidity never exceeds full scale.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.humidity_centi <= 14'd10000))
    else $error("humidity above full scale");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A held pipeline keeps the occupancy of its front and result stages.
  a_hold_front: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(fv_r) && $stable(pv_r))
    else $error("pipeline moved while held");

endmodule

`default_nettype wire

/* src/esc_div.sv */
// Pipelined unsigned 32-by-32 restoring divider, one quotient bit per stage.
// Depends on esc_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module esc_div #(
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [31:0]   dividend,
  input  wire logic [31:0]   divisor,
  input  wire logic [PW-1:0] side_in,
  output      logic          out_valid,
  output      logic [31:0]   quotient,
  output      logic [PW-1:0] side_out
);
  import esc_pkg::*;

  logic          v_r    [DW];
  logic [DW-1:0] rem_r  [DW];
  logic [DW-1:0] num_r  [DW];
  logic [DW-1:0] den_r  [DW];
  logic [DW-1:0] quo_r  [DW];
  logic [PW-1:0] side_r [DW];

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic          v_prev;
    logic [DW-1:0] rem_prev, num_prev, den_prev, quo_prev;
    logic [PW-1:0] side_prev;
    logic [DW:0]   shifted, trial;

    // Stage input: the ports for the first step, the previous stage otherwise.
    if (k == 0) begin : g_first
      assign v_prev    = in_valid;
      assign rem_prev  = '0;
      assign num_prev  = dividend;
      assign den_prev  = divisor;
      assign quo_prev  = '0;
      assign side_prev = side_in;
    end else begin : g_next
      assign v_prev    = v_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign num_prev  = num_r[k-1];
      assign den_prev  = den_r[k-1];
      assign quo_prev  = quo_r[k-1];
      assign side_prev = side_r[k-1];
    end

    // Shift in the next dividend bit and try the subtraction.
    assign shifted = {rem_prev, num_prev[DW-1]};
    assign trial   = shifted - {1'b0, den_prev};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= trial[DW] ? shifted[DW-1:0] : trial[DW-1:0];
        num_r[k]  <= {num_prev[DW-2:0], 1'b0};
        den_r[k]  <= den_prev;
        quo_r[k]  <= {quo_prev[DW-2:0], ~trial[DW]};
        side_r[k] <= side_prev;
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign quotient  = quo_r[DW-1];
  assign side_out  = side_r[DW-1];

endmodule

`default_nettype wire

/* sim/tb.sv */
// Testbench for env_sensor_compensation: drives raw sample triples with random gaps,
// predicts temperature, pressure and humidity per sample and checks each result in order.
// Depends on esc_pkg, the channel interfaces in esc_if and the block itself.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import esc_pkg::*;

  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] pressure;
    logic [13:0] humidity;
  } comp_result_t;

  localparam int PIPE_LATENCY = 52;
  localparam int STALL_LIMIT  = 2000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_wdata;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  env_sensor_compensation u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Local copy of the calibration registers.
  logic [47:0] cal_temp;
  logic [63:0] cal_plow;
  logic [63:0] cal_pmid;
  logic [15:0] cal_plast;
  logic [63:0] cal_hum;

  comp_result_t expected_results[$];
  int  error_count;
  int  idle_cycles;
  bit  quiet_mode;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Signed field of a packed register, sign-extended to 32 bits.
  function automatic logic [31:0] sfield(input logic [63:0] r, input int pos, input int bits);
    logic [31:0] v;
    v = 32'(r >> pos) & ((32'd1 << bits) - 1);
    if (v[bits-1]) v = v | ~((32'd1 << bits) - 1);
    return v;
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // Compensation of one raw triple with the current calibration.
  function automatic comp_result_t compensate(input logic [19:0] ut20, input logic [19:0] up20,
                                              input logic [15:0] uh16);
    logic [31:0] ut, up, uh, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6, a, b, c, d, fine, pres, hum;
    comp_result_t r;
    ut = 32'(ut20); up = 32'(up20); uh = 32'(uh16);
    t1 = 32'(cal_temp[15:0]); t2 = sfield(64'(cal_temp), 16, 16);
    t3 = sfield(64'(cal_temp), 32, 16);
    p1 = 32'(cal_plow[15:0]); p2 = sfield(cal_plow, 16, 16);
    p3 = sfield(cal_plow, 32, 16); p4 = sfield(cal_plow, 48, 16);
    p5 = sfield(cal_pmid, 0, 16); p6 = sfield(cal_pmid, 16, 16);
    p7 = sfield(cal_pmid, 32, 16); p8 = sfield(cal_pmid, 48, 16);
    p9 = sfield(64'(cal_plast), 0, 16);
    h1 = 32'(cal_hum[7:0]); h2 = sfield(cal_hum, 8, 16); h3 = 32'(cal_hum[31:24]);
    h4 = sfield(cal_hum, 32, 12); h5 = sfield(cal_hum, 44, 12); h6 = sfield(cal_hum, 56, 8);

    // Temperature and fine temperature.
    a = sra(((ut >> 3) - (t1 << 1)) * t2, 11);
    d = (ut >> 4) - t1;
    b = sra(d * d, 12);
    b = sra(b * t3, 14);
    fine = a + b;
    r.temperature = sra(fine * 32'd5 + 32'd128, 8);

    // Pressure, with the zero divisor and large scaled pressure cases.
    a = sra(fine, 1) - 32'd64000;
    d = sra(a, 2);
    b = sra(d * d, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    c = sra(p3 * sra(d * d, 13), 3);
    a = sra(c + sra(p2 * a, 1), 18);
    a = sra((32'd32768 + a) * p1, 15);
    if (a == 0) begin
      pres = 0;
    end else begin
      pres = ((32'd1048576 - up) - sra(b, 12)) * 32'd3125;
      if (pres < 32'h80000000) pres = (pres << 1) / a;
      else pres = (pres / a) * 32'd2;
      c = sra(p9 * (((pres >> 3) * (pres >> 3)) >> 13), 12);
      d = sra((pres >> 2) * p8, 13);
      pres = pres + sra(c + d + p7, 4);
    end
    r.pressure = pres;

    // Humidity, clamped in Q10.22 before conversion.
    a = fine - 32'd76800;
    b = sra((uh << 14) - (h4 << 20) - (h5 * a) + 32'd16384, 15);
    c = sra(sra(a * h6, 10) * (sra(a * h3, 11) + 32'd32768), 10) + 32'd2097152;
    a = b * sra(c * h2 + 32'd8192, 14);
    d = sra(a, 15);
    a = a - sra(sra(d * d, 7) * h1, 4);
    if (a[31]) a = 0;
    if (a > 32'd419430400) a = 32'd419430400;
    hum = a >> 12;
    hum = (hum >> 10) * 32'd100 + (((hum & 32'h3FF) * 32'd1000) >> 10) / 32'd10;
    r.humidity = hum[13:0];
    return r;
  endfunction

  // Random gap with valid low, now and then, unless idling is off.
  task automatic random_gap();
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Transfer one raw triple and record its expected result.
  // Valid stays high so that the next sample can follow without a gap.
  task automatic send_sample(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
    random_gap();
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= t;
    in_ch.raw_pressure <= p;
    in_ch.raw_humidity <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(compensate(t, p, h));
  endtask

  // One register write; the caller drops the write enable after the last one.
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_TEMP:  cal_temp = value[47:0];
      REG_PLOW:  cal_plow = value;
      REG_PMID:  cal_pmid = value;
      REG_PLAST: cal_plast = value[15:0];
      REG_HUM:   cal_hum = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pl,
                                  input logic [63:0] pm, input logic [15:0] p9,
                                  input logic [63:0] hc);
    wait_drained();
    write_reg(REG_TEMP, 64'(tc));
    write_reg(REG_PLOW, pl);
    write_reg(REG_PMID, pm);
    write_reg(REG_PLAST, 64'(p9));
    write_reg(REG_HUM, hc);
    cfg_we <= 1'b0;
  endtask

  // Typical datasheet-like calibration so that the formulas land in range.
  task automatic load_typical();
    load_calibration({16'd50, 16'd26435, 16'd27504},
                     {16'd2855, 16'hD4E0, 16'd3024, 16'd36477},
                     {16'hC0A8, 16'hFFF9, 16'd15500, 16'd140},
                     16'd4285,
                     {8'h1E, 12'd0, 12'd339, 8'd0, 16'd361, 8'd75});
  endtask

  task automatic test_reset_defaults();
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
  endtask

  task automatic test_typical_calibration();
    load_typical();
    send_sample(20'd519888, 20'd415148, 16'd32000);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd519888, 20'd0, 16'hFFFF);
    send_sample(20'd400000, 20'hFFFFF, 16'd0);
    send_sample(20'd600000, 20'd300000, 16'd20000);
  endtask

  // Extreme coefficients: all ones, sign bits, and zero divisor with P1 zero.
  task automatic test_extreme_calibration();
    load_calibration('1, '1, '1, 16'hFFFF, '1);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    load_calibration({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'h0000},
                     {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000,
                     {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
    send_sample(20'd12345, 20'd54321, 16'd4321);
    send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
    load_calibration({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                     {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF,
                     {8'h7F, 12'h7FF, 12'h7FF, 8'h00, 16'h7FFF, 8'h00});
    send_sample(20'd0, 20'hFFFFF, 16'd0);
    send_sample(20'h80000, 20'h80000, 16'h8000);
  endtask

  // Random samples; every 150 samples the calibration is reloaded, typical or fully random with equal odds.
  task automatic test_random_samples(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        if ($urandom_range(0, 1) == 0) load_typical();
        else load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                              {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
      end
      if (i == count - 100) quiet_mode = 1'b1;
      if ($urandom_range(0, 3) == 0)
        send_sample(20'($urandom), 20'($urandom), 16'($urandom));
      else
        send_sample(20'($urandom_range(380000, 620000)), 20'($urandom_range(200000, 500000)),
                    16'($urandom_range(15000, 50000)));
    end
  endtask

  // Result side: random stalls, then compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result temp=%0d pres=%0d hum=%0d", $time,
                   out_ch.temperature_centi, out_ch.pressure_pa, out_ch.humidity_centi);
          error_count++;
        end else begin
          comp_result_t exp_r;
          exp_r = expected_results.pop_front();
          if (out_ch.temperature_centi !== exp_r.temperature) begin
            $display("%0t: temperature expected %0d actual %0d", $time,
                     $signed(exp_r.temperature), out_ch.temperature_centi);
            error_count++;
          end
          if (out_ch.pressure_pa !== exp_r.pressure) begin
            $display("%0t: pressure expected %0d actual %0d", $time,
                     exp_r.pressure, out_ch.pressure_pa);
            error_count++;
          end
          if (out_ch.humidity_centi !== exp_r.humidity) begin
            $display("%0t: humidity expected %0d actual %0d", $time,
                     exp_r.humidity, out_ch.humidity_centi);
            error_count++;
          end
        end
      end
      if (quiet_mode) out_ch.ready <= 1'b1;
      else if (idle_cycles > 0) begin
        out_ch.ready <= 1'b0;
        idle_cycles <= idle_cycles - 1;
      end else if ($urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        idle_cycles <= $urandom_range(0, 6);
      end else out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  int stall_count;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    in_ch.raw_humidity = '0;
    cal_temp = '0; cal_plow = '0; cal_pmid = '0; cal_plast = '0; cal_hum = '0;
    error_count = 0;
    quiet_mode = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_typical_calibration();
    test_extreme_calibration();
    test_random_samples(900);
    wait_drained();
    repeat (PIPE_LATENCY) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
src/esc_pkg.sv
src/esc_if.sv
src/esc_div.sv
src/env_sensor_compensation.sv
sim/tb.sv
